// ===== design/mwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Maze walker package
// Shared types, codes and direction helpers for the maze walker block.
// ----------------------------------------------------------------------------
package mwf_pkg;

    localparam int unsigned COORD_W = 5;

    typedef logic [COORD_W-1:0] t_coord;
    // One bit wider, so that a neighbor one step past either edge stays distinct.
    typedef logic [COORD_W:0]   t_coord_x;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_AUTO    = 3'd1,
        CMD_UP      = 3'd2,
        CMD_DOWN    = 3'd3,
        CMD_LEFT    = 3'd4,
        CMD_RIGHT   = 3'd5,
        CMD_READ    = 3'd6,
        CMD_RESTART = 3'd7
    } t_command;

    typedef enum logic [1:0] {
        HD_EAST  = 2'd0,
        HD_SOUTH = 2'd1,
        HD_NORTH = 2'd2,
        HD_WEST  = 2'd3
    } t_heading;

    typedef enum logic [1:0] {
        CFG_START_ROW = 2'd0,
        CFG_START_COL = 2'd1,
        CFG_GOAL_ROW  = 2'd2,
        CFG_GOAL_COL  = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;

    localparam t_coord RST_START_ROW = 5'd2;
    localparam t_coord RST_START_COL = 5'd0;
    localparam t_coord RST_GOAL_ROW  = 5'd10;
    localparam t_coord RST_GOAL_COL  = 5'd21;

    typedef struct packed {
        t_command   command;
        t_coord     cell_row;
        t_coord     cell_col;
        logic [1:0] cell_kind;
    } t_cmd_item;

    typedef struct packed {
        t_coord     pos_row;
        t_coord     pos_col;
        t_heading   heading;
        logic       moved;
        logic       at_goal;
        logic [1:0] read_kind;
    } t_result;

    typedef struct packed {
        t_coord   row;
        t_coord   col;
        t_heading heading;
    } t_walker;

    typedef struct packed {
        logic east;
        logic south;
        logic north;
        logic west;
    } t_nbr_open;

    function automatic t_heading right_of(t_heading h);
        t_heading d;
        unique case (h)
            HD_EAST:  d = HD_SOUTH;
            HD_SOUTH: d = HD_WEST;
            HD_NORTH: d = HD_EAST;
            HD_WEST:  d = HD_NORTH;
        endcase
        return d;
    endfunction

    function automatic t_heading left_of(t_heading h);
        t_heading d;
        unique case (h)
            HD_EAST:  d = HD_NORTH;
            HD_SOUTH: d = HD_EAST;
            HD_NORTH: d = HD_WEST;
            HD_WEST:  d = HD_SOUTH;
        endcase
        return d;
    endfunction

    function automatic t_heading back_of(t_heading h);
        t_heading d;
        unique case (h)
            HD_EAST:  d = HD_WEST;
            HD_SOUTH: d = HD_NORTH;
            HD_NORTH: d = HD_SOUTH;
            HD_WEST:  d = HD_EAST;
        endcase
        return d;
    endfunction

    function automatic logic dir_open(t_nbr_open n, t_heading d);
        logic o;
        unique case (d)
            HD_EAST:  o = n.east;
            HD_SOUTH: o = n.south;
            HD_NORTH: o = n.north;
            HD_WEST:  o = n.west;
        endcase
        return o;
    endfunction

    function automatic t_coord step_row(t_coord r, t_heading d);
        t_coord s;
        unique case (d)
            HD_SOUTH: s = r + t_coord'(1);
            HD_NORTH: s = r - t_coord'(1);
            HD_EAST:  s = r;
            HD_WEST:  s = r;
        endcase
        return s;
    endfunction

    function automatic t_coord step_col(t_coord c, t_heading d);
        t_coord s;
        unique case (d)
            HD_EAST:  s = c + t_coord'(1);
            HD_WEST:  s = c - t_coord'(1);
            HD_SOUTH: s = c;
            HD_NORTH: s = c;
        endcase
        return s;
    endfunction

endpackage

// ===== design/maze_wall_follower.sv =====
// ----------------------------------------------------------------------------
// Maze wall follower
// Grid maze walker with cell access, right-hand auto steps and manual moves.
// ----------------------------------------------------------------------------
// The block takes one command word in every clock cycle and busy never goes
// high. A command accepted at one rising edge has its result word on
// o_result for exactly one cycle, marked by o_result_valid, starting right
// after the next rising edge; results come in command order and cannot be
// held off. This timing comes from the grid memory: the cell grid
// sits in four banks split by row and column parity, each with one write port
// and two registered read ports, so that the four neighbors of the walker
// (two in the bank of the same row, two in the bank of the same column) are
// read at the edge that accepts a command. The read addresses come from the
// walker's position as updated by the command before, so back-to-back
// commands see each other's moves. A write cell command updates the grid at
// the edge that accepts it. Cells outside the grid read as walls, and writes
// there are dropped. The grid has no reset and no clearing pass: a cell must
// be written before it is read or walked next to. The configuration registers
// take a write at any edge with i_cfg_we high and should only change while
// no command is in flight.
// ----------------------------------------------------------------------------
module maze_wall_follower
    import mwf_pkg::*;
#(
    parameter int unsigned ROWS = 32,
    parameter int unsigned COLS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_item i_cmd,
    input  logic      i_cfg_we,
    input  t_cfg_idx  i_cfg_idx,
    input  t_coord    i_cfg_data,
    output logic      o_result_valid,
    output t_result   o_result
);

    // Only the first 2**COORD_W rows and columns can be addressed.
    localparam int unsigned COORD_SPAN = 2 ** COORD_W;
    localparam int unsigned NR = (ROWS < COORD_SPAN) ? ROWS : COORD_SPAN;
    localparam int unsigned NC = (COLS < COORD_SPAN) ? COLS : COORD_SPAN;
    // Each bank holds every second row and every second column.
    localparam int unsigned RAW    = $clog2((NR + 1) / 2);
    localparam int unsigned CAW    = $clog2((NC + 1) / 2);
    localparam int unsigned ADDR_W = RAW + CAW;

    function automatic logic [ADDR_W-1:0] bank_addr(t_coord_x r, t_coord_x c);
        return {r[RAW:1], c[CAW:1]};
    endfunction

    function automatic logic in_grid(t_coord_x r, t_coord_x c);
        return (r < t_coord_x'(NR)) && (c < t_coord_x'(NC));
    endfunction

    // Configuration registers.
    t_coord r_start_row;
    t_coord r_start_col;
    t_coord r_goal_row;
    t_coord r_goal_col;

    // Walker state and the command register.
    t_walker  r_cur;
    t_walker  n_cur;
    logic     r_v;
    t_command r_command;
    t_coord   r_cell_row;
    t_coord   r_cell_col;

    // Result register.
    logic    r_result_valid;
    t_result r_result;
    t_result n_result;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Grid banks. Bank index is {row parity, column parity}.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] raddr_a [4];
    logic [ADDR_W-1:0] raddr_b [4];
    logic [1:0]        rdata_a [4];
    logic [1:0]        rdata_b [4];
    logic [3:0]        bank_we;
    logic [ADDR_W-1:0] waddr;
    logic [1:0]        wdata;
    logic              rd_sel;

    t_coord_x in_row_x;
    t_coord_x in_col_x;
    t_coord_x nx_row;
    t_coord_x nx_col;
    t_coord_x nx_row_s;
    t_coord_x nx_row_n;
    t_coord_x nx_col_e;
    t_coord_x nx_col_w;

    assign in_row_x = {1'b0, i_cmd.cell_row};
    assign in_col_x = {1'b0, i_cmd.cell_col};

    // Reads follow the position the walker has after the command in flight.
    assign nx_row   = {1'b0, n_cur.row};
    assign nx_col   = {1'b0, n_cur.col};
    assign nx_row_s = nx_row + t_coord_x'(1);
    assign nx_row_n = nx_row - t_coord_x'(1);
    assign nx_col_e = nx_col + t_coord_x'(1);
    assign nx_col_w = nx_col - t_coord_x'(1);

    assign rd_sel = accept && (i_cmd.command == CMD_READ);
    assign waddr  = bank_addr(in_row_x, in_col_x);
    // A kind code above the other mark is stored as the other mark.
    assign wdata  = (i_cmd.cell_kind > KIND_OTHER) ? KIND_OTHER : i_cmd.cell_kind;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BID = 2'(b);

        always_comb begin
            raddr_a[b] = '0;
            raddr_b[b] = '0;
            priority if (rd_sel) begin
                raddr_a[b] = bank_addr(in_row_x, in_col_x);
            end else if ((BID[1] == n_cur.row[0]) && (BID[0] != n_cur.col[0])) begin
                raddr_a[b] = bank_addr(nx_row, nx_col_e);
                raddr_b[b] = bank_addr(nx_row, nx_col_w);
            end else if ((BID[1] != n_cur.row[0]) && (BID[0] == n_cur.col[0])) begin
                raddr_a[b] = bank_addr(nx_row_s, nx_col);
                raddr_b[b] = bank_addr(nx_row_n, nx_col);
            end else begin
                raddr_a[b] = '0;
            end
        end

        assign bank_we[b] = accept && (i_cmd.command == CMD_WRITE)
                            && in_grid(in_row_x, in_col_x)
                            && ({i_cmd.cell_row[0], i_cmd.cell_col[0]} == BID);

        mwf_bank #(
            .ADDR_W (ADDR_W)
        ) u_bank (
            .i_clk     (i_clk),
            .i_we      (bank_we[b]),
            .i_waddr   (waddr),
            .i_wdata   (wdata),
            .i_raddr_a (raddr_a[b]),
            .i_raddr_b (raddr_b[b]),
            .o_rdata_a (rdata_a[b]),
            .o_rdata_b (rdata_b[b])
        );
    end

    // ------------------------------------------------------------------
    // Neighbor decode for the registered command.
    // ------------------------------------------------------------------
    logic [1:0] h_bank;
    logic [1:0] v_bank;
    logic [1:0] c_bank;
    t_coord_x   cr_row;
    t_coord_x   cr_col;
    t_coord_x   cl_row;
    t_coord_x   cl_col;
    t_nbr_open  nbr;
    logic [1:0] read_kind;

    assign cr_row = {1'b0, r_cur.row};
    assign cr_col = {1'b0, r_cur.col};
    assign cl_row = {1'b0, r_cell_row};
    assign cl_col = {1'b0, r_cell_col};

    // The east and west neighbors share the bank of the walker's row; north
    // and south share the bank of its column.
    assign h_bank = {r_cur.row[0], ~r_cur.col[0]};
    assign v_bank = {~r_cur.row[0], r_cur.col[0]};
    assign c_bank = {r_cell_row[0], r_cell_col[0]};

    always_comb begin
        nbr.east  = in_grid(cr_row, cr_col + t_coord_x'(1))
                    && (rdata_a[h_bank] == KIND_OPEN);
        nbr.west  = in_grid(cr_row, cr_col - t_coord_x'(1))
                    && (rdata_b[h_bank] == KIND_OPEN);
        nbr.south = in_grid(cr_row + t_coord_x'(1), cr_col)
                    && (rdata_a[v_bank] == KIND_OPEN);
        nbr.north = in_grid(cr_row - t_coord_x'(1), cr_col)
                    && (rdata_b[v_bank] == KIND_OPEN);
    end

    assign read_kind = in_grid(cl_row, cl_col) ? rdata_a[c_bank] : KIND_WALL;

    mwf_step u_step (
        .i_valid     (r_v),
        .i_command   (r_command),
        .i_cur       (r_cur),
        .i_nbr       (nbr),
        .i_read_kind (read_kind),
        .i_start_row (r_start_row),
        .i_start_col (r_start_col),
        .i_goal_row  (r_goal_row),
        .i_goal_col  (r_goal_col),
        .o_next      (n_cur),
        .o_result    (n_result)
    );

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v            <= 1'b0;
            r_result_valid <= 1'b0;
            r_cur.row      <= RST_START_ROW;
            r_cur.col      <= RST_START_COL;
            r_cur.heading  <= HD_EAST;
            r_start_row    <= RST_START_ROW;
            r_start_col    <= RST_START_COL;
            r_goal_row     <= RST_GOAL_ROW;
            r_goal_col     <= RST_GOAL_COL;
        end else begin
            r_v            <= accept;
            r_result_valid <= r_v;
            r_cur          <= n_cur;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_START_ROW: r_start_row <= i_cfg_data;
                    CFG_START_COL: r_start_col <= i_cfg_data;
                    CFG_GOAL_ROW:  r_goal_row  <= i_cfg_data;
                    CFG_GOAL_COL:  r_goal_col  <= i_cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_command  <= i_cmd.command;
            r_cell_row <= i_cmd.cell_row;
            r_cell_col <= i_cmd.cell_col;
        end
        r_result <= n_result;
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

// ===== design/mwf_bank.sv =====
// ----------------------------------------------------------------------------
// Maze walker grid bank
// One quarter of the cell grid: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mwf_bank #(
    parameter int unsigned ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [1:0]        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [1:0]        o_rdata_a,
    output logic [1:0]        o_rdata_b
);

    localparam int unsigned DEPTH = 2 ** ADDR_W;

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rdata_a;
    logic [1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/mwf_step.sv =====
// ----------------------------------------------------------------------------
// Maze walker step logic
// Works out the walker's next position and heading, and the result word.
// ----------------------------------------------------------------------------
module mwf_step
    import mwf_pkg::*;
(
    input  logic       i_valid,
    input  t_command   i_command,
    input  t_walker    i_cur,
    input  t_nbr_open  i_nbr,
    input  logic [1:0] i_read_kind,
    input  t_coord     i_start_row,
    input  t_coord     i_start_col,
    input  t_coord     i_goal_row,
    input  t_coord     i_goal_col,
    output t_walker    o_next,
    output t_result    o_result
);

    logic       at_dest;
    logic       do_move;
    t_heading   mv_dir;
    t_heading   rh;
    t_heading   lh;
    t_heading   bh;
    logic [1:0] rk;
    t_walker    nxt;

    assign at_dest = (i_cur.row == i_goal_row) && (i_cur.col == i_goal_col);
    assign rh      = right_of(i_cur.heading);
    assign lh      = left_of(i_cur.heading);
    assign bh      = back_of(i_cur.heading);

    always_comb begin
        nxt     = i_cur;
        do_move = 1'b0;
        mv_dir  = HD_EAST;
        rk      = KIND_OPEN;
        if (i_valid) begin
            unique case (i_command)
                CMD_WRITE: begin
                    rk = KIND_OPEN;
                end
                CMD_AUTO: begin
                    if (!at_dest) begin
                        // Right hand first, then ahead, then left, then turn back.
                        priority if (dir_open(i_nbr, rh)) begin
                            do_move     = 1'b1;
                            mv_dir      = rh;
                            nxt.heading = rh;
                        end else if (dir_open(i_nbr, i_cur.heading)) begin
                            do_move = 1'b1;
                            mv_dir  = i_cur.heading;
                        end else if (dir_open(i_nbr, lh)) begin
                            do_move     = 1'b1;
                            mv_dir      = lh;
                            nxt.heading = lh;
                        end else begin
                            // The heading turns back even when that cell is blocked.
                            do_move     = dir_open(i_nbr, bh);
                            mv_dir      = bh;
                            nxt.heading = bh;
                        end
                    end
                end
                CMD_UP: begin
                    do_move = i_nbr.north;
                    mv_dir  = HD_NORTH;
                end
                CMD_DOWN: begin
                    do_move = i_nbr.south;
                    mv_dir  = HD_SOUTH;
                end
                CMD_LEFT: begin
                    do_move = i_nbr.west && !at_dest;
                    mv_dir  = HD_WEST;
                end
                CMD_RIGHT: begin
                    do_move = i_nbr.east;
                    mv_dir  = HD_EAST;
                end
                CMD_READ: begin
                    rk = i_read_kind;
                end
                CMD_RESTART: begin
                    nxt.row     = i_start_row;
                    nxt.col     = i_start_col;
                    nxt.heading = HD_EAST;
                end
            endcase
        end
        if (do_move) begin
            nxt.row = step_row(i_cur.row, mv_dir);
            nxt.col = step_col(i_cur.col, mv_dir);
        end
    end

    assign o_next = nxt;

    always_comb begin
        o_result.pos_row   = nxt.row;
        o_result.pos_col   = nxt.col;
        o_result.heading   = nxt.heading;
        o_result.moved     = (nxt.row != i_cur.row) || (nxt.col != i_cur.col);
        o_result.at_goal   = (nxt.row == i_goal_row) && (nxt.col == i_goal_col);
        o_result.read_kind = rk;
    end

endmodule

// ===== design/mwf_checker.sv =====
// ----------------------------------------------------------------------------
// Maze walker checker
// Port-level assertions on command flow and result contents.
// ----------------------------------------------------------------------------
module mwf_checker
    import mwf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_cmd_item i_cmd,
    input logic      o_result_valid,
    input t_result   o_result
);

    // Every accepted command produces a result once it has passed r_v and r_result_valid.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("accepted command produced no result");

    // No result appears without an earlier accepted command.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy && i_rst_n, 2))
        else $error("result without an accepted command");

    // Between back-to-back results the moved flag tracks the position change.
    a_moved_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid)) |->
            (o_result.moved == ((o_result.pos_row != $past(o_result.pos_row))
                             || (o_result.pos_col != $past(o_result.pos_col)))))
        else $error("moved flag disagrees with position change");

    // Only a read command reports a cell kind.
    a_read_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && ($past(i_cmd.command, 2) != CMD_READ)) |->
            (o_result.read_kind == KIND_OPEN))
        else $error("read kind set on a non-read command");

    // A restart always leaves the walker heading east.
    a_restart_east: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && ($past(i_cmd.command, 2) == CMD_RESTART)) |->
            (o_result.heading == HD_EAST))
        else $error("restart did not face east");

endmodule

bind maze_wall_follower mwf_checker u_mwf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_cmd          (i_cmd),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);
